FILE: rtl/closed_catmull_rom_spline_unit_defines.svh
// Assertion macros shared by the spline unit.
`ifndef CLOSED_CATMULL_ROM_SPLINE_UNIT_DEFINES_SVH
`define CLOSED_CATMULL_ROM_SPLINE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define CCR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spline unit check failed");
`define CCR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spline unit check failed");
`else
`define CCR_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define CCR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/ccr_pkg.sv
package ccr_pkg;

    // Request and result payloads.
    typedef struct packed {
        logic               command;
        logic [7:0]         index;
        logic signed [31:0] in_x;
        logic signed [31:0] in_y;
    } ccr_req_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic               last;
    } ccr_rsp_t;

    // One control point as stored in memory.
    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
    } ccr_point_t;

    // Curve parameter handed to the blend pipeline.
    typedef struct packed {
        logic        valid;
        logic        last;
        logic [15:0] tq;
    } ccr_issue_t;

    // Pipeline status back to the sequencer.
    typedef struct packed {
        logic adv;
        logic busy;
    } ccr_stat_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_COEF,
        ST_RUN
    } ccr_state_t;

    // Register indexes on the configuration port.
    localparam logic REG_POINT_COUNT = 1'b0;
    localparam logic REG_PER_SEGMENT = 1'b1;

    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_SEGMENT = 1'b1;

endpackage

FILE: rtl/ccr_ram.sv
module ccr_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                                    clk,
    input  logic                                    en,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                        wdata,
    output logic [WIDTH-1:0]                        rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Single port, registered read.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end
endmodule

FILE: rtl/ccr_recip.sv
module ccr_recip (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [6:0]  divisor,
    output logic        done,
    output logic [16:0] quo,
    output logic [6:0]  rem
);
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [6:0]  div_reg, div_next;
    logic [6:0]  rem_reg, rem_next;
    logic [16:0] quo_reg, quo_next;
    logic [7:0]  shifted;
    logic        ge;

    // Restoring division of 65536 by the divisor, one quotient bit a cycle.
    always_comb
    begin
        shifted   = {rem_reg, (cnt_reg == 5'd0)};
        ge        = shifted >= {1'b0, div_reg};
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            cnt_next  = 5'd0;
            busy_next = 1'b1;
            done_next = 1'b0;
            div_next  = divisor;
            rem_next  = 7'd0;
            quo_next  = 17'd0;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? 7'(shifted - {1'b0, div_reg}) : 7'(shifted);
            quo_next = {quo_reg[15:0], ge};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd16)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= 5'd0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_reg <= div_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;
    assign rem  = rem_reg;
endmodule

FILE: rtl/ccr_blend.sv
module ccr_blend (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 coef_load,
    input  ccr_pkg::ccr_point_t  pts [4],
    input  ccr_pkg::ccr_issue_t  issue,
    output ccr_pkg::ccr_stat_t   stat,
    output logic                 out_valid,
    input  logic                 out_ready,
    output ccr_pkg::ccr_rsp_t    out_data
);
    import ccr_pkg::*;

    logic signed [36:0] cx_reg [4];
    logic signed [36:0] cy_reg [4];
    logic signed [36:0] ax [4];
    logic signed [36:0] ay [4];
    logic        adv;
    logic        v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, out_valid_reg;
    logic        l1_reg, l2_reg, l3_reg, l4_reg, l5_reg;
    logic [15:0] tq1_reg, tq2_reg, tq3_reg;
    logic [16:0] t2_2_reg, t2_3_reg, t3_3_reg;
    logic [31:0] sq_full, cu_full;
    logic [33:0] cu_prod;
    logic signed [63:0] px_reg [4];
    logic signed [63:0] py_reg [4];
    logic signed [63:0] sx_reg, sy_reg;
    ccr_rsp_t out_reg;

    function automatic logic signed [36:0] coef(input logic [1:0] k,
        input logic signed [36:0] a0, input logic signed [36:0] a1,
        input logic signed [36:0] a2, input logic signed [36:0] a3);
        logic signed [36:0] r;
        case (k)
            2'd0:    r = a1 <<< 1;
            2'd1:    r = a2 - a0;
            2'd2:    r = (a0 <<< 1) - (a1 <<< 2) - a1 + (a2 <<< 2) - a3;
            default: r = a1 + (a1 <<< 1) - a2 - (a2 <<< 1) + a3 - a0;
        endcase
        return r;
    endfunction

    function automatic logic signed [31:0] round_sat(input logic signed [63:0] s);
        logic signed [63:0] r;
        logic signed [31:0] o;
        r = s >>> 17;
        if (r > 64'sh0000_0000_7FFF_FFFF)
        begin
            o = 32'sh7FFF_FFFF;
        end
        else if (r < -64'sh0000_0000_8000_0000)
        begin
            o = 32'sh8000_0000;
        end
        else
        begin
            o = r[31:0];
        end
        return o;
    endfunction

    // The whole pipeline moves when the output register can take a result.
    assign adv       = !out_valid_reg || out_ready;
    assign stat.adv  = adv;
    assign stat.busy = v1_reg || v2_reg || v3_reg || v4_reg || v5_reg;

    // Coefficients for both axes, captured once per segment.
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            ax[k] = 37'(pts[k].x);
            ay[k] = 37'(pts[k].y);
        end
    end

    always_ff @(posedge clk)
    begin
        if (coef_load)
        begin
            for (int k = 0; k < 4; k++)
            begin
                cx_reg[k] <= coef(2'(k), ax[0], ax[1], ax[2], ax[3]);
                cy_reg[k] <= coef(2'(k), ay[0], ay[1], ay[2], ay[3]);
            end
        end
    end

    // Powers of t, rounded to Q0.16.
    assign sq_full = 32'(tq1_reg) * 32'(tq1_reg);
    assign cu_prod = 34'(t2_2_reg) * 34'(tq2_reg);
    assign cu_full = 32'((cu_prod + 34'd32768) >> 16);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tq1_reg  <= issue.tq;
            l1_reg   <= issue.last;
            t2_2_reg <= 17'((33'(sq_full) + 33'd32768) >> 16);
            tq2_reg  <= tq1_reg;
            l2_reg   <= l1_reg;
            t3_3_reg <= 17'(cu_full);
            t2_3_reg <= t2_2_reg;
            tq3_reg  <= tq2_reg;
            l3_reg   <= l2_reg;
            // Weighted terms of the cubic.
            px_reg[0] <= 64'(cx_reg[0]) <<< 16;
            px_reg[1] <= cx_reg[1] * $signed({2'b00, tq3_reg});
            px_reg[2] <= cx_reg[2] * $signed({1'b0, t2_3_reg});
            px_reg[3] <= cx_reg[3] * $signed({1'b0, t3_3_reg});
            py_reg[0] <= 64'(cy_reg[0]) <<< 16;
            py_reg[1] <= cy_reg[1] * $signed({2'b00, tq3_reg});
            py_reg[2] <= cy_reg[2] * $signed({1'b0, t2_3_reg});
            py_reg[3] <= cy_reg[3] * $signed({1'b0, t3_3_reg});
            l4_reg    <= l3_reg;
            // Sum with the rounding bias.
            sx_reg <= px_reg[0] + px_reg[1] + px_reg[2] + px_reg[3] + 64'sd65536;
            sy_reg <= py_reg[0] + py_reg[1] + py_reg[2] + py_reg[3] + 64'sd65536;
            l5_reg <= l4_reg;
            out_reg.out_x <= round_sat(sx_reg);
            out_reg.out_y <= round_sat(sy_reg);
            out_reg.last  <= l5_reg;
        end
    end

    // Stage valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg        <= issue.valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            v5_reg        <= v4_reg;
            out_valid_reg <= v5_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
endmodule

FILE: rtl/closed_catmull_rom_spline_unit.sv
// Closed uniform Catmull-Rom spline unit.
// A segment request reads four points and runs the reciprocal, then issues
// one curve point a cycle while the output is not stalled; the results
// leave through the blend pipeline and its output register.
// Reset (rst_n low, asynchronous) restores point_count 4 and 8 points per segment.
module closed_catmull_rom_spline_unit #(
    parameter int MAX_POINTS      = 256,
    parameter int MAX_PER_SEGMENT = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              in_valid,
    output logic              in_ready,
    input  ccr_pkg::ccr_req_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output ccr_pkg::ccr_rsp_t out_data
);
    import ccr_pkg::*;

`include "closed_catmull_rom_spline_unit_defines.svh"

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);

    logic [8:0]  point_count_reg;
    logic [6:0]  per_seg_reg;
    ccr_state_t  state_reg, state_next;
    logic [CW-1:0] cnt_eff, idx_c, i0, i2, i3;
    logic [6:0]  n_eff;
    logic        acc, idx_ok, do_load, do_seg;
    logic [AW-1:0] addr_reg [4];
    logic [AW-1:0] ram_addr;
    logic        ram_en, ram_we;
    logic [63:0] ram_rdata;
    logic [2:0]  rd_cnt_reg, rd_cnt_next;
    logic        rd_pend_reg, rd_pend_next;
    logic [1:0]  rd_slot_reg;
    ccr_point_t  pts_reg [4];
    logic [6:0]  n_reg, j_reg;
    logic [16:0] q_reg;
    logic [6:0]  r_reg;
    logic [7:0]  r_sum;
    logic [16:0] q_sum;
    logic        div_done;
    logic [16:0] div_quo;
    logic [6:0]  div_rem;
    logic        coef_load;
    ccr_issue_t  issue;
    ccr_stat_t   stat;

    // Configuration registers.
    assign pready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg <= 9'd4;
            per_seg_reg     <= 7'd8;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[2])
                REG_POINT_COUNT: point_count_reg <= pwdata[8:0];
                REG_PER_SEGMENT: per_seg_reg     <= pwdata[6:0];
                default:         point_count_reg <= point_count_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_POINT_COUNT: prdata = {23'd0, point_count_reg};
            REG_PER_SEGMENT: prdata = {25'd0, per_seg_reg};
            default:         prdata = 32'd0;
        endcase
    end

    // Effective counts and neighbor indexes on the ring.
    always_comb
    begin
        cnt_eff = (int'(point_count_reg) > MAX_POINTS) ? CW'(MAX_POINTS)
                                                       : CW'(point_count_reg);
        n_eff   = (int'(per_seg_reg) > MAX_PER_SEGMENT) ? 7'(MAX_PER_SEGMENT)
                                                        : per_seg_reg;
        idx_c   = CW'(in_data.index);
        i0      = (idx_c == '0) ? CW'(cnt_eff - CW'(1)) : CW'(idx_c - CW'(1));
        i2      = (CW'(idx_c + CW'(1)) == cnt_eff) ? '0 : CW'(idx_c + CW'(1));
        i3      = (CW'(i2 + CW'(1)) == cnt_eff) ? '0 : CW'(i2 + CW'(1));
    end

    assign in_ready = (state_reg == ST_IDLE) && !stat.busy;
    assign acc      = in_valid && in_ready;
    assign idx_ok   = int'(in_data.index) < int'(cnt_eff);
    assign do_load  = acc && idx_ok && (in_data.command == CMD_LOAD);
    assign do_seg   = acc && idx_ok && (in_data.command == CMD_SEGMENT) && (n_eff != 7'd0);

    // Point memory: loads write, a segment reads its four points.
    always_comb
    begin
        ram_en   = do_load;
        ram_we   = do_load;
        ram_addr = AW'(in_data.index);
        rd_cnt_next  = rd_cnt_reg;
        rd_pend_next = 1'b0;
        if (state_reg == ST_PREP && rd_cnt_reg != 3'd4)
        begin
            ram_en       = 1'b1;
            ram_addr     = addr_reg[rd_cnt_reg[1:0]];
            rd_cnt_next  = rd_cnt_reg + 3'd1;
            rd_pend_next = 1'b1;
        end
        if (do_seg)
        begin
            rd_cnt_next = 3'd0;
        end
    end

    ccr_ram #(
        .WIDTH (64),
        .DEPTH (MAX_POINTS)
    ) u_ram (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata ({in_data.in_x, in_data.in_y}),
        .rdata (ram_rdata)
    );

    ccr_recip u_recip (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (do_seg),
        .divisor (n_eff),
        .done    (div_done),
        .quo     (div_quo),
        .rem     (div_rem)
    );

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        coef_load  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (do_seg)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                if (div_done && rd_cnt_reg == 3'd4 && !rd_pend_reg)
                begin
                    state_next = ST_COEF;
                end
            end
            ST_COEF:
            begin
                coef_load  = 1'b1;
                state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (issue.valid && issue.last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            rd_cnt_reg  <= 3'd4;
            rd_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_cnt_reg  <= rd_cnt_next;
            rd_pend_reg <= rd_pend_next;
        end
    end

    // Curve parameter: t = j/n kept as quotient and remainder.
    assign r_sum = {1'b0, r_reg} + {1'b0, div_rem};
    assign q_sum = q_reg + div_quo;

    assign issue.valid = (state_reg == ST_RUN) && stat.adv;
    assign issue.last  = (j_reg == 7'(n_reg - 7'd1));
    assign issue.tq    = q_reg[15:0];

    always_ff @(posedge clk)
    begin
        if (do_seg)
        begin
            addr_reg[0] <= AW'(i0);
            addr_reg[1] <= AW'(idx_c);
            addr_reg[2] <= AW'(i2);
            addr_reg[3] <= AW'(i3);
            n_reg       <= n_eff;
        end
        rd_slot_reg <= rd_cnt_reg[1:0];
        if (rd_pend_reg)
        begin
            pts_reg[rd_slot_reg] <= ram_rdata;
        end
        if (coef_load)
        begin
            j_reg <= 7'd0;
            q_reg <= 17'd0;
            r_reg <= n_reg >> 1;
        end
        else if (issue.valid)
        begin
            j_reg <= j_reg + 7'd1;
            if (r_sum >= {1'b0, n_reg})
            begin
                r_reg <= 7'(r_sum - {1'b0, n_reg});
                q_reg <= q_sum + 17'd1;
            end
            else
            begin
                r_reg <= r_sum[6:0];
                q_reg <= q_sum;
            end
        end
    end

    ccr_blend u_blend (
        .clk       (clk),
        .rst_n     (rst_n),
        .coef_load (coef_load),
        .pts       (pts_reg),
        .issue     (issue),
        .stat      (stat),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // Checks on the sequencer.
    `CCR_ASSERT_SAME(a_ready_idle, clk, rst_n, in_ready, state_reg == ST_IDLE && !stat.busy)
    `CCR_ASSERT_SAME(a_issue_run, clk, rst_n, issue.valid, state_reg == ST_RUN)
    `CCR_ASSERT_NEXT(a_last_ends, clk, rst_n, issue.valid && issue.last, state_reg == ST_IDLE)
    `CCR_ASSERT_NEXT(a_coef_run, clk, rst_n, state_reg == ST_COEF, state_reg == ST_RUN && j_reg == 7'd0)
endmodule
